// ----- design/mbl_pkg.sv -----
// Shared types and constants for the monochrome bitmap to LCD bus converter.
`default_nettype none
package mbl_pkg;

  localparam int MBL_QUEUE_DEPTH = 4;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXELS = 1'b1;

  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_PAGE_ADDR    = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic [3:0] PIXELS_PER_BYTE = 4'd8;

  localparam logic [3:0] STEP_COL_CMD  = 4'd0;
  localparam logic [3:0] STEP_XS_HI    = 4'd1;
  localparam logic [3:0] STEP_XS_LO    = 4'd2;
  localparam logic [3:0] STEP_XE_HI    = 4'd3;
  localparam logic [3:0] STEP_XE_LO    = 4'd4;
  localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
  localparam logic [3:0] STEP_YS_HI    = 4'd6;
  localparam logic [3:0] STEP_YS_LO    = 4'd7;
  localparam logic [3:0] STEP_YE_HI    = 4'd8;
  localparam logic [3:0] STEP_YE_LO    = 4'd9;
  localparam logic [3:0] STEP_WR_CMD   = 4'd10;

  typedef enum logic [2:0] {
    REG_FORE_COLOR   = 3'd0,
    REG_BACK_COLOR   = 3'd1,
    REG_LEFT_COLUMN  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_TOP_ROW      = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [15:0] left_column;
    logic [15:0] image_width;
    logic [15:0] top_row;
    logic [15:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] image_byte;
    logic [2:0] take_m1;
  } job_t;

endpackage
`default_nettype wire

// ----- design/mbl_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none
module mbl_regs
  import mbl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cfg_t             cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fore_color   <= 16'hFFFF;
      cfg.back_color   <= 16'h0000;
      cfg.left_column  <= 16'h0000;
      cfg.image_width  <= 16'd8;
      cfg.top_row      <= 16'h0000;
      cfg.image_height <= 16'd8;
    end else if (wr_en) begin
      unique case (idx)
        REG_FORE_COLOR:   cfg.fore_color   <= pwdata[15:0];
        REG_BACK_COLOR:   cfg.back_color   <= pwdata[15:0];
        REG_LEFT_COLUMN:  cfg.left_column  <= pwdata[15:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[15:0];
        REG_TOP_ROW:      cfg.top_row      <= pwdata[15:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORE_COLOR:   prdata = {16'h0000, cfg.fore_color};
      REG_BACK_COLOR:   prdata = {16'h0000, cfg.back_color};
      REG_LEFT_COLUMN:  prdata = {16'h0000, cfg.left_column};
      REG_IMAGE_WIDTH:  prdata = {16'h0000, cfg.image_width};
      REG_TOP_ROW:      prdata = {16'h0000, cfg.top_row};
      REG_IMAGE_HEIGHT: prdata = {16'h0000, cfg.image_height};
      default:          prdata = 32'h0000_0000;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/mbl_front.sv -----
// Front end: accepts input beats, tracks row and column, and queues jobs.
`default_nettype none
module mbl_front
  import mbl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [7:0] image_byte,
  input  wire cfg_t       cfg,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  logic [15:0] column_count;
  logic [15:0] row_count;
  logic        active;
  logic        accept;
  logic        drawing;
  logic [15:0] remain;
  logic [3:0]  take;
  logic        row_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign drawing  = active && (row_count < cfg.image_height);

  always_comb begin
    remain   = (column_count < cfg.image_width) ? (cfg.image_width - column_count) : 16'd0;
    take     = (remain >= 16'(PIXELS_PER_BYTE)) ? PIXELS_PER_BYTE : remain[3:0];
    row_done = (remain <= 16'(PIXELS_PER_BYTE));
  end

  assign push = accept && ((kind == KIND_WINDOW) || (drawing && (take != 4'd0)));
  assign push_job.kind       = kind;
  assign push_job.image_byte = image_byte;
  assign push_job.take_m1    = 3'(take - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 16'd0;
      row_count    <= 16'd0;
      active       <= 1'b0;
    end else if (accept) begin
      if (kind == KIND_WINDOW) begin
        column_count <= 16'd0;
        row_count    <= 16'd0;
        active       <= 1'b1;
      end else if (drawing) begin
        if (row_done) begin
          column_count <= 16'd0;
          row_count    <= row_count + 16'd1;
        end else begin
          column_count <= column_count + 16'(take);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/mbl_queue.sv -----
// Short job queue between the front end and the bus sequencer.
`default_nettype none
module mbl_queue
  import mbl_pkg::*;
#(
  parameter int DEPTH = MBL_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output job_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/mbl_back.sv -----
// Bus sequencer: turns queued jobs into byte strobes behind an output register.
`default_nettype none
module mbl_back
  import mbl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       q_valid,
  input  wire job_t       q_head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            is_data,
  output logic [7:0]      bus_byte,
  output logic            last
);

  logic        busy;
  logic        job_kind;
  logic [7:0]  job_byte;
  logic [2:0]  job_take_m1;
  logic [3:0]  step;
  logic        advance;
  logic        step_last;
  logic        cur_is_data;
  logic [7:0]  cur_byte;
  logic [15:0] x_end;
  logic [15:0] y_end;
  logic [15:0] color;

  assign advance = !out_valid || out_ready;
  assign x_end   = cfg.left_column + cfg.image_width - 16'd1;
  assign y_end   = cfg.top_row + cfg.image_height - 16'd1;
  assign color   = job_byte[~step[3:1]] ? cfg.fore_color : cfg.back_color;

  always_comb begin
    if (job_kind == KIND_WINDOW) begin
      step_last = (step == STEP_WR_CMD);
    end else begin
      step_last = (step[3:1] == job_take_m1) && step[0];
    end
    pop = q_valid && (!busy || (advance && step_last));
  end

  always_comb begin
    cur_is_data = 1'b1;
    cur_byte    = 8'h00;
    if (job_kind == KIND_PIXELS) begin
      cur_byte = step[0] ? color[7:0] : color[15:8];
    end else begin
      unique case (step)
        STEP_COL_CMD: begin
          cur_is_data = 1'b0;
          cur_byte    = CMD_COLUMN_ADDR;
        end
        STEP_XS_HI: cur_byte = cfg.left_column[15:8];
        STEP_XS_LO: cur_byte = cfg.left_column[7:0];
        STEP_XE_HI: cur_byte = x_end[15:8];
        STEP_XE_LO: cur_byte = x_end[7:0];
        STEP_PAGE_CMD: begin
          cur_is_data = 1'b0;
          cur_byte    = CMD_PAGE_ADDR;
        end
        STEP_YS_HI: cur_byte = cfg.top_row[15:8];
        STEP_YS_LO: cur_byte = cfg.top_row[7:0];
        STEP_YE_HI: cur_byte = y_end[15:8];
        STEP_YE_LO: cur_byte = y_end[7:0];
        STEP_WR_CMD: begin
          cur_is_data = 1'b0;
          cur_byte    = CMD_MEMORY_WRITE;
        end
        default: begin
          cur_is_data = 1'b0;
          cur_byte    = CMD_MEMORY_WRITE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && busy && step_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_kind    <= q_head.kind;
      job_byte    <= q_head.image_byte;
      job_take_m1 <= q_head.take_m1;
      step        <= 4'd0;
    end else if (advance && busy) begin
      step <= step + 4'd1;
    end
    if (advance && busy) begin
      is_data  <= cur_is_data;
      bus_byte <= cur_byte;
      last     <= step_last;
    end
  end

endmodule
`default_nettype wire

// ----- design/mono_bitmap_to_lcd_bus.sv -----
// Top level of the monochrome bitmap to LCD bus converter.
// An item passes the job queue and job registers before its first beat is registered.
// A start item gives 11 beats; a bitmap byte gives two beats per drawn pixel, up to 16.
// The bus sequencer sends one beat per cycle unless out_ready stalls the output.
// A four-entry job queue lets input beats be taken while earlier jobs are still sent.
// Synchronous reset clears the counters, queue and out_valid; registers take defaults.
`default_nettype none
module mono_bitmap_to_lcd_bus
  import mbl_pkg::*;
#(
  parameter int QUEUE_DEPTH = MBL_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  image_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_data,
  output logic [7:0]       bus_byte,
  output logic             last
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  assign pready = 1'b1;

  mbl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mbl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .image_byte (image_byte),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (q_push),
    .push_job   (q_push_job)
  );

  mbl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  mbl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_data   (is_data),
    .bus_byte  (bus_byte),
    .last      (last)
  );

endmodule
`default_nettype wire

// ----- design/mbl_checker.sv -----
// Port-level checker for the converter and its bind to the top level.
`default_nettype none
module mbl_checker
  import mbl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_data,
  input wire logic [7:0]  bus_byte,
  input wire logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bus_byte) && $stable(is_data)
      && $stable(last))
    else $error("Output beat changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_data |-> bus_byte == CMD_COLUMN_ADDR || bus_byte == CMD_PAGE_ADDR
      || bus_byte == CMD_MEMORY_WRITE)
    else $error("Unknown command byte on the bus.");

  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_data |-> last == (bus_byte == CMD_MEMORY_WRITE))
    else $error("Window set-up does not end on the memory-write command.");

endmodule

bind mono_bitmap_to_lcd_bus mbl_checker u_mbl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_data   (is_data),
  .bus_byte  (bus_byte),
  .last      (last)
);
`default_nettype wire
